/* sv/mss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants, codes and types of the monophonic step sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int STEP_COUNT = 64;
  localparam int ROW_COUNT  = 25;
  localparam int KEY_COUNT  = 20;

  localparam int STEP_W = $clog2(STEP_COUNT);
  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int KEY_W  = $clog2(KEY_COUNT);
  localparam int CNT_W  = $clog2(STEP_COUNT + 1);

  localparam int OP_W    = 4;
  localparam int IDX_W   = 6;
  localparam int NROW_W  = 5;
  localparam int KIDX_W  = 5;
  localparam int DUP_W   = 7;
  localparam int TPS_W   = 5;
  localparam int OCT_W   = 4;
  localparam int CFG_W   = 5;
  localparam int CFGI_W  = 1;
  localparam int POS_W   = 6;
  localparam int EL_W    = 6;
  localparam int PSUM_W  = 9;

  localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
  localparam logic [OP_W-1:0] OP_PLAY       = 4'd1;
  localparam logic [OP_W-1:0] OP_STOP       = 4'd2;
  localparam logic [OP_W-1:0] OP_PLAY_PAUSE = 4'd3;
  localparam logic [OP_W-1:0] OP_STEP_SET   = 4'd4;
  localparam logic [OP_W-1:0] OP_STEP_CLEAR = 4'd5;
  localparam logic [OP_W-1:0] OP_DUPLICATE  = 4'd6;
  localparam logic [OP_W-1:0] OP_KEY_DOWN   = 4'd7;
  localparam logic [OP_W-1:0] OP_KEY_UP     = 4'd8;

  localparam logic [CFGI_W-1:0] CFG_TICKS  = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_OCTAVE = 1'b1;

  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_CONTROL  = 8'hB0;
  localparam logic [6:0] CTL_ALL_OFF = 7'd123;
  localparam logic [6:0] VEL_ON      = 7'd127;
  localparam logic [6:0] VEL_OFF     = 7'd0;
  localparam logic [6:0] PITCH_MAX   = 7'd127;
  localparam logic [EL_W-1:0] TICK_SAT = 6'd63;
  localparam int SEMITONES = 12;

  localparam logic [TPS_W-1:0] TPS_RESET = 5'd5;
  localparam logic [OCT_W-1:0] OCT_RESET = 4'd2;
  localparam logic [OCT_W-1:0] OCT_MAX   = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CLEAR,
    S_CHORD,
    S_DUP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]       status_byte;
    logic [6:0]       data_one;
    logic [6:0]       data_two;
    logic [POS_W-1:0] play_position;
    logic             last_message;
  } msg_t;

  typedef struct packed {
    logic              we;
    logic [STEP_W-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic [STEP_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

/* sv/mss_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/mss_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_out_reg
// Output word register: holds one message until the consumer takes it.
// ----------------------------------------------------------------------------
module mss_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  mss_pkg::msg_t      msg_in,
  output logic               free,
  output logic               msg_valid,
  input  wire logic          msg_stall,
  output mss_pkg::msg_t      msg_out
);
  import mss_pkg::*;

  assign free = !msg_valid || !msg_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (load) begin
      msg_valid <= 1'b1;
    end else if (!msg_stall) begin
      msg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg_out <= msg_in;
    end
  end

endmodule
`default_nettype wire

/* sv/mss_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_core
// Sequencer control: item decode, pattern RAM access, duplicate walk,
// chord detection and message scheduling.
// ----------------------------------------------------------------------------
module mss_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [mss_pkg::OP_W-1:0]      op,
  input  wire logic [mss_pkg::IDX_W-1:0]     step_index,
  input  wire logic [mss_pkg::NROW_W-1:0]    note_row,
  input  wire logic [mss_pkg::KIDX_W-1:0]    key_index,
  input  wire logic [mss_pkg::DUP_W-1:0]     dup_length,
  input  wire logic                          cfg_valid,
  input  wire logic [mss_pkg::CFGI_W-1:0]    cfg_index,
  input  wire logic [mss_pkg::CFG_W-1:0]     cfg_data,
  output mss_pkg::ram_req_t                  ram_req,
  input  wire logic [mss_pkg::ROW_W-1:0]     ram_rdata,
  input  wire logic                          out_free,
  output logic                               msg_load,
  output mss_pkg::msg_t                      msg
);
  import mss_pkg::*;

  localparam int MOD_STEPS = (1 << ROW_W) / SEMITONES;

  function automatic logic [3:0] row_mod12(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = v;
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (r >= ROW_W'(SEMITONES)) begin
        r = r - ROW_W'(SEMITONES);
      end
    end
    return 4'(r);
  endfunction

  state_t state, state_next;

  logic [TPS_W-1:0]      ticks_per_step;
  logic [OCT_W-1:0]      octave;
  logic [STEP_COUNT-1:0] filled;
  logic [STEP_W-1:0]     cursor;
  logic                  running;
  logic [EL_W-1:0]       elapsed;
  logic [6:0]            sounding_pitch;
  logic                  sounding_valid;
  logic [KEY_COUNT-1:0]  held_keys;
  logic [KEY_W-1:0]      key_offset;
  logic                  major_flag;
  logic                  minor_flag;

  logic                  off_pend;
  logic                  on_pend;
  logic                  ctl_pend;
  logic [6:0]            off_pitch;
  logic                  fetch_hit;
  logic [STEP_W-1:0]     clr_step;
  logic [ROW_W-1:0]      clr_row;
  logic [CNT_W-1:0]      dup_m;
  logic [CNT_W-1:0]      dup_j;
  logic [CNT_W-1:0]      dup_p;
  logic                  wr_pend;
  logic [STEP_W-1:0]     wr_addr;

  logic                  accept;
  logic [STEP_W-1:0]     cursor_inc;
  logic [EL_W-1:0]       el_inc;
  logic                  fire;
  logic                  step_ok;
  logic                  key_ok;
  logic                  dup_ok;
  logic                  dup_over;
  logic [CNT_W-1:0]      dup_j_inc;
  logic [CNT_W:0]        dup_end;
  logic [3:0]            row_mod;
  logic [ROW_W:0]        adj_row;
  logic [PSUM_W-1:0]     pitch_sum;
  logic [6:0]            pitch;
  logic [KEY_W-1:0]      first_k;
  logic [KEY_W-1:0]      second_k;
  logic [1:0]            key_cnt;
  logic [KEY_W-1:0]      key_gap;
  logic                  pend_any;

  assign accept     = item_valid && (state == S_IDLE);
  assign item_stall = (state != S_IDLE);

  assign cursor_inc = (cursor == STEP_W'(STEP_COUNT - 1)) ? '0 : cursor + 1'b1;
  assign el_inc     = (elapsed == TICK_SAT) ? elapsed : elapsed + 1'b1;
  assign fire       = running && (el_inc >= EL_W'(ticks_per_step));
  assign step_ok    = (int'(step_index) < STEP_COUNT) && (int'(note_row) < ROW_COUNT);
  assign key_ok     = (int'(key_index) < KEY_COUNT);
  assign dup_ok     = (dup_length != '0) && (int'(dup_length) <= STEP_COUNT);

  assign dup_end   = {1'b0, dup_p} + {1'b0, dup_m};
  assign dup_over  = (dup_j == '0) && (dup_end > (CNT_W + 1)'(STEP_COUNT));
  assign dup_j_inc = (dup_j + 1'b1 == dup_m) ? '0 : dup_j + 1'b1;

  assign row_mod = row_mod12(ram_rdata);
  always_comb begin
    adj_row = {1'b0, ram_rdata};
    if (row_mod == 4'd4 && minor_flag) begin
      adj_row = {1'b0, ram_rdata} - 1'b1;
    end else if (row_mod == 4'd3 && major_flag) begin
      adj_row = {1'b0, ram_rdata} + 1'b1;
    end
  end
  assign pitch_sum = PSUM_W'(adj_row) + PSUM_W'(octave) * PSUM_W'(SEMITONES)
                   + PSUM_W'(key_offset);
  assign pitch = (pitch_sum > PSUM_W'(PITCH_MAX)) ? PITCH_MAX : pitch_sum[6:0];

  always_comb begin
    first_k  = '0;
    second_k = '0;
    key_cnt  = 2'd0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (held_keys[k]) begin
        if (key_cnt == 2'd0) begin
          first_k = KEY_W'(k);
          key_cnt = 2'd1;
        end else if (key_cnt == 2'd1) begin
          second_k = KEY_W'(k);
          key_cnt  = 2'd2;
        end
      end
    end
  end
  assign key_gap = second_k - first_k;

  assign pend_any = off_pend || on_pend || ctl_pend;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_TICK:       state_next = fire ? S_FETCH : S_IDLE;
            OP_STOP:       state_next = S_EMIT;
            OP_PLAY_PAUSE: state_next = running ? S_EMIT : S_IDLE;
            OP_STEP_CLEAR: state_next = step_ok ? S_CLEAR : S_IDLE;
            OP_DUPLICATE:  state_next = dup_ok ? S_DUP : S_IDLE;
            OP_KEY_DOWN:   state_next = (key_ok && !held_keys[key_index[KEY_W-1:0]])
                                        ? S_CHORD : S_IDLE;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_FETCH: state_next = S_EMIT;
      S_CLEAR: state_next = S_IDLE;
      S_CHORD: state_next = S_IDLE;
      S_DUP:   state_next = dup_over ? S_IDLE : S_DUP;
      S_EMIT: begin
        if (!pend_any || (out_free && !(off_pend && on_pend))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = wr_addr;
    ram_req.wdata = ram_rdata;
    ram_req.raddr = cursor_inc;
    msg_load      = 1'b0;
    msg.status_byte   = ST_CONTROL;
    msg.data_one      = CTL_ALL_OFF;
    msg.data_two      = VEL_OFF;
    msg.play_position = POS_W'(cursor);
    msg.last_message  = 1'b1;
    case (state)
      S_IDLE: begin
        if (op == OP_STEP_CLEAR) begin
          ram_req.raddr = step_index[STEP_W-1:0];
        end
        if (accept && op == OP_STEP_SET && step_ok) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = step_index[STEP_W-1:0];
          ram_req.wdata = note_row[ROW_W-1:0];
        end
      end
      S_DUP: begin
        ram_req.raddr = dup_j[STEP_W-1:0];
        ram_req.we    = wr_pend;
      end
      S_EMIT: begin
        msg_load = out_free && pend_any;
        if (off_pend) begin
          msg.status_byte  = ST_NOTE_OFF;
          msg.data_one     = off_pitch;
          msg.last_message = !on_pend;
        end else if (on_pend) begin
          msg.status_byte = ST_NOTE_ON;
          msg.data_one    = sounding_pitch;
          msg.data_two    = VEL_ON;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ticks_per_step <= TPS_RESET;
      octave         <= OCT_RESET;
      filled         <= '0;
      cursor         <= '0;
      running        <= 1'b0;
      elapsed        <= '0;
      sounding_pitch <= '0;
      sounding_valid <= 1'b0;
      held_keys      <= '0;
      key_offset     <= '0;
      major_flag     <= 1'b0;
      minor_flag     <= 1'b0;
      off_pend       <= 1'b0;
      on_pend        <= 1'b0;
      ctl_pend       <= 1'b0;
      wr_pend        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_TICKS:  ticks_per_step <= cfg_data[TPS_W-1:0];
          CFG_OCTAVE: begin
            if (cfg_data[OCT_W-1:0] <= OCT_MAX) begin
              octave <= cfg_data[OCT_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_TICK: begin
                elapsed <= fire ? '0 : el_inc;
                if (fire) begin
                  off_pend       <= sounding_valid;
                  off_pitch      <= sounding_pitch;
                  sounding_valid <= 1'b0;
                  cursor         <= cursor_inc;
                  fetch_hit      <= filled[cursor_inc];
                end
              end
              OP_PLAY: begin
                running <= 1'b1;
                cursor  <= '0;
              end
              OP_STOP: begin
                ctl_pend <= 1'b1;
                running  <= 1'b0;
                cursor   <= '0;
              end
              OP_PLAY_PAUSE: begin
                ctl_pend <= running;
                running  <= !running;
              end
              OP_STEP_SET: begin
                if (step_ok) begin
                  filled[step_index[STEP_W-1:0]] <= 1'b1;
                end
              end
              OP_STEP_CLEAR: begin
                clr_step <= step_index[STEP_W-1:0];
                clr_row  <= note_row[ROW_W-1:0];
              end
              OP_DUPLICATE: begin
                dup_m <= CNT_W'(dup_length);
                dup_p <= CNT_W'(dup_length);
                dup_j <= '0;
              end
              OP_KEY_DOWN: begin
                if (key_ok && !held_keys[key_index[KEY_W-1:0]]) begin
                  held_keys[key_index[KEY_W-1:0]] <= 1'b1;
                  key_offset <= key_index[KEY_W-1:0];
                end
              end
              OP_KEY_UP: begin
                if (key_ok) begin
                  held_keys[key_index[KEY_W-1:0]] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: begin
          if (fetch_hit) begin
            sounding_pitch <= pitch;
            sounding_valid <= 1'b1;
            on_pend        <= 1'b1;
          end
        end
        S_CLEAR: begin
          if (filled[clr_step] && ram_rdata == clr_row) begin
            filled[clr_step] <= 1'b0;
          end
        end
        S_CHORD: begin
          major_flag <= (key_cnt == 2'd2) && (key_gap == KEY_W'(4));
          minor_flag <= (key_cnt == 2'd2) && (key_gap == KEY_W'(3));
        end
        S_DUP: begin
          wr_pend <= !dup_over;
          if (!dup_over) begin
            filled[dup_p[STEP_W-1:0]] <= filled[dup_j[STEP_W-1:0]];
            wr_addr <= dup_p[STEP_W-1:0];
            dup_p   <= dup_p + 1'b1;
            dup_j   <= dup_j_inc;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (off_pend) begin
              off_pend <= 1'b0;
            end else if (on_pend) begin
              on_pend <= 1'b0;
            end else begin
              ctl_pend <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/monophonic_step_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// monophonic_step_sequencer
// 64-step monophonic pattern sequencer giving MIDI note and control words.
// Sequence: a firing tick is accepted in idle, reads pattern RAM in fetch,
//   then loads each message word (up to 2) into the output register in emit.
// Items: new items are taken only in idle; item_stall is high in other states;
//   duplicate walks the pattern RAM one step a cycle through both its ports.
// Reset: synchronous; pattern steps read empty at once through per-step valid
//   flops, with no clearing pass.
// ----------------------------------------------------------------------------
module monophonic_step_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [mss_pkg::OP_W-1:0]      op,
  input  wire logic [mss_pkg::IDX_W-1:0]     step_index,
  input  wire logic [mss_pkg::NROW_W-1:0]    note_row,
  input  wire logic [mss_pkg::KIDX_W-1:0]    key_index,
  input  wire logic [mss_pkg::DUP_W-1:0]     dup_length,
  output logic                               msg_valid,
  input  wire logic                          msg_stall,
  output logic [7:0]                         status_byte,
  output logic [6:0]                         data_one,
  output logic [6:0]                         data_two,
  output logic [mss_pkg::POS_W-1:0]          play_position,
  output logic                               last_message,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mss_pkg::CFGI_W-1:0]    cfg_index,
  input  wire logic [mss_pkg::CFG_W-1:0]     cfg_data
);
  import mss_pkg::*;

  ram_req_t         ram_req;
  logic [ROW_W-1:0] ram_rdata;
  logic             out_free;
  logic             msg_load;
  msg_t             msg_next;
  msg_t             msg_q;

  assign cfg_ready = 1'b1;

  mss_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .step_index (step_index),
    .note_row   (note_row),
    .key_index  (key_index),
    .dup_length (dup_length),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_free   (out_free),
    .msg_load   (msg_load),
    .msg        (msg_next)
  );

  mss_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STEP_COUNT)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  mss_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (msg_load),
    .msg_in    (msg_next),
    .free      (out_free),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_out   (msg_q)
  );

  assign status_byte   = msg_q.status_byte;
  assign data_one      = msg_q.data_one;
  assign data_two      = msg_q.data_two;
  assign play_position = msg_q.play_position;
  assign last_message  = msg_q.last_message;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the monophonic step sequencer. Drives pattern edits,
// key presses and transport ticks through the item channel with random bursts
// and gaps, stalls the message channel on changing patterns, predicts every
// MIDI word from a local copy of the sequencer state and checks each word.
// ----------------------------------------------------------------------------
module testbench;
  import mss_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_WORDS     = 200;
  localparam int MAJOR_THIRD     = 4;
  localparam int MINOR_THIRD     = 3;
  localparam logic [OP_W-1:0] OP_UNUSED_TOP = '1;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [OP_W-1:0]     op = OP_TICK;
  logic [IDX_W-1:0]    step_index = '0;
  logic [NROW_W-1:0]   note_row = '0;
  logic [KIDX_W-1:0]   key_index = '0;
  logic [DUP_W-1:0]    dup_length = '0;
  logic                msg_valid;
  logic                msg_stall = 1'b0;
  logic [7:0]          status_byte;
  logic [6:0]          data_one;
  logic [6:0]          data_two;
  logic [POS_W-1:0]    play_position;
  logic                last_message;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFGI_W-1:0]   cfg_index = CFG_TICKS;
  logic [CFG_W-1:0]    cfg_data = '0;

  // sequencer state as predicted
  logic [ROW_W-1:0]     pattern_rows [STEP_COUNT];
  logic                 pattern_filled [STEP_COUNT];
  logic [POS_W-1:0]     cursor_pos;
  logic                 is_running;
  logic [EL_W-1:0]      tick_count;
  logic [6:0]           held_pitch;
  logic                 note_sounding;
  logic [KEY_COUNT-1:0] keys_down;
  logic [KIDX_W-1:0]    transpose;
  logic                 major_chord;
  logic                 minor_chord;
  logic [TPS_W-1:0]     tick_period;
  logic [OCT_W-1:0]     base_octave;

  msg_t pending_words[$];
  int   mismatches = 0;
  int   burst_left = 0;
  bit   offering = 1'b0;
  int   hold_reqs = 0;
  int   hold_grants = 0;
  int   idle_cycles = 0;

  monophonic_step_sequencer DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .step_index(step_index), .note_row(note_row),
    .key_index(key_index), .dup_length(dup_length),
    .msg_valid(msg_valid), .msg_stall(msg_stall),
    .status_byte(status_byte), .data_one(data_one), .data_two(data_two),
    .play_position(play_position), .last_message(last_message),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic msg_t make_word(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    msg_t w;
    w = '0;
    w.status_byte = st;
    w.data_one = d1;
    w.data_two = d2;
    return w;
  endfunction

  task automatic clear_sequencer();
    for (int i = 0; i < STEP_COUNT; i++) begin
      pattern_rows[i] = '0;
      pattern_filled[i] = 1'b0;
    end
    cursor_pos = '0;
    is_running = 1'b0;
    tick_count = '0;
    held_pitch = '0;
    note_sounding = 1'b0;
    keys_down = '0;
    transpose = '0;
    major_chord = 1'b0;
    minor_chord = 1'b0;
    tick_period = TPS_RESET;
    base_octave = OCT_RESET;
  endtask

  task automatic advance_sequencer(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] s,
                                   input logic [NROW_W-1:0] r, input logic [KIDX_W-1:0] k,
                                   input logic [DUP_W-1:0] d);
    msg_t words[$];
    msg_t w;
    int row, pitch, first, second, found, m, seg, j;
    case (o)
      OP_TICK: begin
        if (tick_count < TICK_SAT) tick_count++;
        if (is_running && tick_count >= tick_period) begin
          tick_count = '0;
          if (note_sounding) begin
            words.push_back(make_word(ST_NOTE_OFF, held_pitch, VEL_OFF));
            note_sounding = 1'b0;
          end
          cursor_pos = cursor_pos + 1'b1;
          if (pattern_filled[cursor_pos]) begin
            row = pattern_rows[cursor_pos];
            if (row % SEMITONES == MAJOR_THIRD && minor_chord) row--;
            else if (row % SEMITONES == MINOR_THIRD && major_chord) row++;
            pitch = row + SEMITONES * base_octave + transpose;
            if (pitch > PITCH_MAX) pitch = PITCH_MAX;
            held_pitch = pitch[6:0];
            note_sounding = 1'b1;
            words.push_back(make_word(ST_NOTE_ON, held_pitch, VEL_ON));
          end
        end
      end
      OP_PLAY: begin
        is_running = 1'b1;
        cursor_pos = '0;
      end
      OP_STOP: begin
        words.push_back(make_word(ST_CONTROL, CTL_ALL_OFF, VEL_OFF));
        is_running = 1'b0;
        cursor_pos = '0;
      end
      OP_PLAY_PAUSE: begin
        if (is_running) begin
          words.push_back(make_word(ST_CONTROL, CTL_ALL_OFF, VEL_OFF));
          is_running = 1'b0;
        end else begin
          is_running = 1'b1;
        end
      end
      OP_STEP_SET: begin
        if (r < ROW_COUNT) begin
          pattern_rows[s] = r[ROW_W-1:0];
          pattern_filled[s] = 1'b1;
        end
      end
      OP_STEP_CLEAR: begin
        if (r < ROW_COUNT && pattern_filled[s] && pattern_rows[s] == r)
          pattern_filled[s] = 1'b0;
      end
      OP_DUPLICATE: begin
        m = d;
        if (m != 0 && m <= STEP_COUNT) begin
          for (seg = 1; seg < STEP_COUNT / m; seg++) begin
            for (j = 0; j < m; j++) begin
              if (seg * m + j < STEP_COUNT) begin
                pattern_rows[seg * m + j] = pattern_rows[j];
                pattern_filled[seg * m + j] = pattern_filled[j];
              end
            end
          end
        end
      end
      OP_KEY_DOWN: begin
        if (k < KEY_COUNT && !keys_down[k]) begin
          keys_down[k] = 1'b1;
          transpose = k;
          major_chord = 1'b0;
          minor_chord = 1'b0;
          found = 0;
          first = 0;
          second = 0;
          for (int i = 0; i < KEY_COUNT; i++) begin
            if (keys_down[i] && found < 2) begin
              if (found == 0) first = i;
              else second = i;
              found++;
            end
          end
          if (found >= 2) begin
            if (second - first == MAJOR_THIRD) major_chord = 1'b1;
            else if (second - first == MINOR_THIRD) minor_chord = 1'b1;
          end
        end
      end
      OP_KEY_UP: begin
        if (k < KEY_COUNT) keys_down[k] = 1'b0;
      end
      default: begin
      end
    endcase
    foreach (words[i]) begin
      w = words[i];
      w.play_position = cursor_pos;
      w.last_message = (i == words.size() - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic send_word(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] s,
                           input logic [NROW_W-1:0] r, input logic [KIDX_W-1:0] k,
                           input logic [DUP_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        if (offering) item_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    offering = 1'b1;
    op <= o;
    step_index <= s;
    note_row <= r;
    key_index <= k;
    dup_length <= d;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    advance_sequencer(o, s, r, k, d);
  endtask

  task automatic go_quiet();
    if (offering) item_valid <= 1'b0;
    offering = 1'b0;
    burst_left = 0;
  endtask

  task automatic settle();
    go_quiet();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [TPS_W-1:0] tps, input logic [OCT_W-1:0] oct);
    logic spare;
    spare = $urandom_range(0, 1);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TICKS;
    cfg_data <= tps;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tick_period = tps;
    cfg_index <= CFG_OCTAVE;
    cfg_data <= {spare, oct};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (oct <= OCT_MAX) base_octave = oct;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_word();
    logic [OP_W-1:0]   o;
    logic [IDX_W-1:0]  s;
    logic [NROW_W-1:0] r;
    logic [KIDX_W-1:0] k;
    logic [DUP_W-1:0]  d;
    int pick;
    s = $urandom;
    r = $urandom;
    k = $urandom;
    d = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      o = OP_TICK;
    end else if (pick < 60) begin
      o = OP_STEP_SET;
      if ($urandom_range(0, 7) != 0) r = $urandom_range(0, ROW_COUNT - 1);
    end else if (pick < 68) begin
      o = OP_STEP_CLEAR;
      if (pattern_filled[s] && $urandom_range(0, 1)) r = pattern_rows[s];
    end else if (pick < 72) begin
      o = OP_DUPLICATE;
      if ($urandom_range(0, 5) != 0) d = $urandom_range(1, STEP_COUNT);
    end else if (pick < 87) begin
      o = (pick < 80) ? OP_KEY_DOWN : OP_KEY_UP;
      if ($urandom_range(0, 7) != 0) k = $urandom_range(0, KEY_COUNT - 1);
    end else if (pick < 91) begin
      o = OP_PLAY;
    end else if (pick < 93) begin
      o = OP_STOP;
    end else if (pick < 97) begin
      o = OP_PLAY_PAUSE;
    end else begin
      o = $urandom_range(int'(OP_KEY_UP) + 1, int'(OP_UNUSED_TOP));
    end
    send_word(o, s, r, k, d);
  endtask

  task automatic test_pattern_edits();
    configure(5'd0, OCT_MAX);
    send_word(OP_STEP_SET, 6'd0, 5'd24, '0, '0);
    send_word(OP_STEP_SET, 6'd1, 5'd4, '0, '0);
    send_word(OP_STEP_SET, 6'd2, 5'd15, '0, '0);
    send_word(OP_STEP_SET, 6'd5, 5'd31, '0, '0);
    send_word(OP_STEP_CLEAR, 6'd1, 5'd5, '0, '0);
    send_word(OP_DUPLICATE, '0, '0, '0, 7'd0);
    send_word(OP_DUPLICATE, '1, '1, '1, 7'd127);
    send_word(OP_DUPLICATE, '0, '0, '0, 7'd3);
  endtask

  task automatic test_keys_and_playback();
    send_word(OP_KEY_DOWN, '0, '0, 5'd31, '0);
    send_word(OP_KEY_DOWN, '0, '0, 5'd19, '0);
    send_word(OP_KEY_DOWN, '0, '0, 5'd15, '0);
    send_word(OP_PLAY, '0, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_KEY_DOWN, '0, '0, 5'd12, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_KEY_UP, '0, '0, 5'd12, '0);
    send_word(OP_KEY_DOWN, '0, '0, 5'd15, '0);
  endtask

  task automatic test_transport();
    send_word(OP_STEP_CLEAR, 6'd5, 5'd15, '0, '0);
    send_word(OP_PLAY_PAUSE, '0, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_PLAY_PAUSE, '0, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_STOP, '0, '0, '0, '0);
    send_word(OP_UNUSED_TOP, '1, '1, '1, '1);
  endtask

  task automatic test_random_sweep();
    logic [TPS_W-1:0] tps_list [8];
    logic [OCT_W-1:0] oct_list [8];
    tps_list = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0};
    oct_list = '{4'd0, OCT_MAX, 4'd15, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};
    for (int p = 4; p < 8; p++) begin
      tps_list[p] = $urandom_range(0, 6);
      oct_list[p] = $urandom_range(0, 15);
    end
    for (int p = 0; p < 8; p++) begin
      settle();
      configure(tps_list[p], oct_list[p]);
      repeat (PHASE_WORDS) send_random_word();
    end
  endtask

  task automatic test_output_backpressure();
    settle();
    configure(5'd0, $urandom_range(0, int'(OCT_MAX)));
    for (int i = 0; i < 8; i++)
      send_word(OP_STEP_SET, i, $urandom_range(0, ROW_COUNT - 1), $urandom, $urandom);
    send_word(OP_DUPLICATE, '0, '0, '0, 7'd8);
    send_word(OP_PLAY, '0, '0, '0, '0);
    hold_reqs++;
    repeat (80) send_word(OP_TICK, $urandom, $urandom, $urandom, $urandom);
    send_word(OP_STOP, '0, '0, '0, '0);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    msg_t want;
    if (!rst && msg_valid && !msg_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: status %0h data %0d/%0d", status_byte, data_one, data_two);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        compare_field("status_byte", want.status_byte, status_byte);
        compare_field("data_one", want.data_one, data_one);
        compare_field("data_two", want.data_two, data_two);
        compare_field("play_position", want.play_position, play_position);
        compare_field("last_message", want.last_message, last_message);
      end
    end
  end

  always @(posedge clk) begin
    static int hold_left = 0;
    static int mode_left = 0;
    static rx_mode_t rx_mode = RX_OPEN;
    static logic [1:0] rx_phase = '0;
    if (rst) begin
      msg_stall <= 1'b0;
    end else if (hold_left > 0) begin
      msg_stall <= 1'b1;
      hold_left--;
    end else if (hold_grants != hold_reqs) begin
      hold_grants++;
      hold_left = HOLD_OFF_CYCLES;
      msg_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      rx_phase = rx_phase + 1'b1;
      case (rx_mode)
        RX_OPEN:   msg_stall <= 1'b0;
        RX_SPARSE: msg_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:  msg_stall <= ($urandom_range(0, 3) != 0);
        default:   msg_stall <= rx_phase[1];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (msg_valid && !msg_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_sequencer();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_pattern_edits();
    test_keys_and_playback();
    test_transport();
    test_random_sweep();
    test_output_backpressure();
    settle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
